[rtl/core/cvh_pkg.sv]
// Shared types and constants for the chroma vectorscope histogram.
`timescale 1ns / 1ps

package cvh_pkg;

  // Request codes carried on the op field.
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Bin count width and saturation value.
  localparam int unsigned CNT_W = 8;
  localparam logic [CNT_W-1:0] COUNT_MAX = 8'd255;

  // Q16 chroma coefficients (BT.601 full range).
  localparam int unsigned COEF_W = 16;
  localparam logic [COEF_W-1:0] CB_R = 16'd11059;
  localparam logic [COEF_W-1:0] CB_G = 16'd21709;
  localparam logic [COEF_W-1:0] CB_B = 16'd32768;
  localparam logic [COEF_W-1:0] CR_R = 16'd32768;
  localparam logic [COEF_W-1:0] CR_G = 16'd27439;
  localparam logic [COEF_W-1:0] CR_B = 16'd5329;

  // Product and sum widths; chroma in Q16 always fits below bit COORD_TOP.
  localparam int unsigned PROD_W    = 23;
  localparam int unsigned CALC_W    = 26;
  localparam int unsigned COORD_TOP = 24;
  localparam logic signed [CALC_W-1:0] HALF_Q16 = 26'sd8388608;
  localparam logic signed [CALC_W-1:0] TOP_Q16  = 26'sd16711680;

  // Controller states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_SUM,
    S_RD,
    S_WR
  } cvh_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic calc_mul;
    logic calc_sum;
    logic mem_rd;
    logic mem_wr;
    logic clr_step;
    logic out_load;
  } cvh_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op;
    logic clr_last;
    logic out_free;
  } cvh_sts_t;

endpackage

[rtl/core/cvh_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cvh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/cvh_ctrl.sv]
// Controller state machine that sequences clearing, conversion and bin updates.
`timescale 1ns / 1ps

module cvh_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cvh_pkg::cvh_sts_t sts_i,
  output cvh_pkg::cvh_cmd_t cmd_o
);

  cvh_pkg::cvh_state_e state_q, state_d;

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cvh_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      cvh_pkg::S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = cvh_pkg::S_IDLE;
        end
      end
      cvh_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = cvh_pkg::S_MUL;
        end
      end
      cvh_pkg::S_MUL: begin
        cmd_o.calc_mul = 1'b1;
        if (sts_i.op == cvh_pkg::OP_READ) begin
          state_d = cvh_pkg::S_RD;
        end else begin
          state_d = cvh_pkg::S_SUM;
        end
      end
      cvh_pkg::S_SUM: begin
        cmd_o.calc_sum = 1'b1;
        state_d        = cvh_pkg::S_RD;
      end
      cvh_pkg::S_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = cvh_pkg::S_WR;
      end
      cvh_pkg::S_WR: begin
        // A read request waits here until the output register is free.
        if (sts_i.op == cvh_pkg::OP_ADD || sts_i.out_free) begin
          cmd_o.mem_wr   = 1'b1;
          cmd_o.out_load = (sts_i.op == cvh_pkg::OP_READ);
          state_d        = cvh_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = cvh_pkg::S_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // The clearing pass ends in idle once the last entry is written.
  a_clear_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cvh_pkg::S_CLEAR && sts_i.clr_last) |=> (state_q == cvh_pkg::S_IDLE))
    else $error("clearing pass did not end in idle");

  // Every store write of a request follows its store read.
  a_wr_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mem_wr |-> $past(state_q == cvh_pkg::S_RD) || $past(state_q == cvh_pkg::S_WR))
    else $error("store write without preceding read");
`endif

endmodule

[rtl/core/cvh_datapath.sv]
// Datapath: chroma conversion, bin addressing, count store and output register.
`timescale 1ns / 1ps

module cvh_datapath #(
  parameter int unsigned BIN_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cvh_pkg::cvh_cmd_t           cmd_i,
  output cvh_pkg::cvh_sts_t           sts_o,
  input  logic                        op_i,
  input  logic [7:0]                  red_i,
  input  logic [7:0]                  green_i,
  input  logic [7:0]                  blue_i,
  input  logic [7:0]                  bin_col_i,
  input  logic [7:0]                  bin_row_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [cvh_pkg::CNT_W-1:0]   bin_count_o
);

  localparam int unsigned ADDR_W      = 2 * BIN_BITS;
  localparam int unsigned DEPTH       = 1 << ADDR_W;
  localparam int unsigned COORD_SHIFT = cvh_pkg::COORD_TOP - BIN_BITS;

  // Request registers.
  logic       op_q;
  logic [7:0] red_q, green_q, blue_q;

  // Products of the conversion.
  logic [cvh_pkg::PROD_W-1:0] p_cbr_q, p_cbg_q, p_cbb_q;
  logic [cvh_pkg::PROD_W-1:0] p_crr_q, p_crg_q, p_crb_q;

  // Bin address, clearing counter and output register.
  logic [ADDR_W-1:0]         addr_q, addr_d;
  logic [ADDR_W-1:0]         clr_q, clr_d;
  logic                      out_valid_q, out_valid_d;
  logic [cvh_pkg::CNT_W-1:0] bin_count_q;

  logic [BIN_BITS+7:0]              col_wide, row_wide;
  logic signed [cvh_pkg::CALC_W-1:0] cb_s, cr_s, top_s;
  logic [BIN_BITS-1:0]              pix_col, pix_row;
  logic                             out_free;

  logic                      mem_we;
  logic [ADDR_W-1:0]         mem_waddr;
  logic [cvh_pkg::CNT_W-1:0] mem_wdata, mem_rdata, cnt_inc;

  // Capture the request.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q    <= op_i;
      red_q   <= red_i;
      green_q <= green_i;
      blue_q  <= blue_i;
    end
  end

  // Constant multiplications, one register stage.
  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_mul) begin
      p_cbr_q <= cvh_pkg::PROD_W'(cvh_pkg::CB_R) * cvh_pkg::PROD_W'(red_q);
      p_cbg_q <= cvh_pkg::PROD_W'(cvh_pkg::CB_G) * cvh_pkg::PROD_W'(green_q);
      p_cbb_q <= cvh_pkg::PROD_W'(cvh_pkg::CB_B) * cvh_pkg::PROD_W'(blue_q);
      p_crr_q <= cvh_pkg::PROD_W'(cvh_pkg::CR_R) * cvh_pkg::PROD_W'(red_q);
      p_crg_q <= cvh_pkg::PROD_W'(cvh_pkg::CR_G) * cvh_pkg::PROD_W'(green_q);
      p_crb_q <= cvh_pkg::PROD_W'(cvh_pkg::CR_B) * cvh_pkg::PROD_W'(blue_q);
    end
  end

  // Sum the products into Cb and Cr, then clamp and cut out the bin coordinates.
  always_comb begin
    cb_s = cvh_pkg::HALF_Q16
         + $signed(cvh_pkg::CALC_W'(p_cbb_q))
         - $signed(cvh_pkg::CALC_W'(p_cbr_q))
         - $signed(cvh_pkg::CALC_W'(p_cbg_q));
    cr_s = cvh_pkg::HALF_Q16
         + $signed(cvh_pkg::CALC_W'(p_crr_q))
         - $signed(cvh_pkg::CALC_W'(p_crg_q))
         - $signed(cvh_pkg::CALC_W'(p_crb_q));
    top_s   = cvh_pkg::TOP_Q16 - cr_s;
    pix_col = cb_s[cvh_pkg::CALC_W-1] ? '0 : cb_s[COORD_SHIFT +: BIN_BITS];
    pix_row = top_s[cvh_pkg::CALC_W-1] ? '0 : top_s[COORD_SHIFT +: BIN_BITS];
  end

  // Read requests take their bin from the request; the low bits fit the axis.
  assign col_wide = {{BIN_BITS{1'b0}}, bin_col_i};
  assign row_wide = {{BIN_BITS{1'b0}}, bin_row_i};

  // Bin address register.
  always_comb begin
    addr_d = addr_q;
    if (cmd_i.load_in) begin
      addr_d = {row_wide[BIN_BITS-1:0], col_wide[BIN_BITS-1:0]};
    end else if (cmd_i.calc_sum) begin
      addr_d = {pix_row, pix_col};
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
  end

  // Clearing counter walks the whole store once after reset.
  assign clr_d = cmd_i.clr_step ? clr_q + ADDR_W'(1) : clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else begin
      clr_q <= clr_d;
    end
  end

  // Saturating increment for an add, zero for a read or the clearing pass.
  assign cnt_inc   = (mem_rdata == cvh_pkg::COUNT_MAX) ? cvh_pkg::COUNT_MAX
                                                       : mem_rdata + cvh_pkg::CNT_W'(1);
  assign mem_we    = cmd_i.mem_wr | cmd_i.clr_step;
  assign mem_waddr = cmd_i.clr_step ? clr_q : addr_q;
  assign mem_wdata = (cmd_i.clr_step || op_q == cvh_pkg::OP_READ) ? '0 : cnt_inc;

  cvh_ram #(
    .WIDTH(cvh_pkg::CNT_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (cmd_i.mem_rd),
    .raddr_i(addr_q),
    .rdata_o(mem_rdata)
  );

  // Output register; it is free when empty or being taken this cycle.
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_d = cmd_i.out_load ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      bin_count_q <= mem_rdata;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign bin_count_o    = bin_count_q;
  assign sts_o.op       = op_q;
  assign sts_o.clr_last = &clr_q;
  assign sts_o.out_free = out_free;

`ifndef NO_ASSERTIONS
  // A result is never loaded over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !(out_valid_q && out_stall_i))
    else $error("output register overwritten while stalled");

  // The clearing pass and request updates never write the store together.
  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.mem_wr && cmd_i.clr_step))
    else $error("two writers on the count store");
`endif

endmodule

[rtl/core/chroma_vectorscope_histogram.sv]
// Top level of the chroma vectorscope histogram: controller plus datapath.
//
//   Channel   Direction  Handshake                   Payload
//   request   in         in_valid_i / in_stall_o     op_i, red_i, green_i, blue_i,
//                                                    bin_col_i, bin_row_i
//   result    out        out_valid_o / out_stall_i   bin_count_o
//
// One request is worked at a time by the controller's read-modify-write sequence
// on the single count store: an add passes through MUL, SUM, RD and WR before the
// next accept, and a read skips SUM and waits in WR until the output register is free.
// After reset a clearing pass writes zero to every one of the 2^(2*BIN_BITS) bins
// (65536 at the default), with in_stall_o held high.
// A read result waits in the output register while out_stall_i is high; further
// requests are still accepted, and only a following read holds until it is taken.
`timescale 1ns / 1ps

module chroma_vectorscope_histogram #(
  parameter int unsigned BIN_BITS = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      op_i,
  input  logic [7:0]                red_i,
  input  logic [7:0]                green_i,
  input  logic [7:0]                blue_i,
  input  logic [7:0]                bin_col_i,
  input  logic [7:0]                bin_row_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [cvh_pkg::CNT_W-1:0] bin_count_o
);

  cvh_pkg::cvh_cmd_t cmd;
  cvh_pkg::cvh_sts_t sts;

  // Sequencing of requests and the clearing pass.
  cvh_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // Conversion, count store and output register.
  cvh_datapath #(
    .BIN_BITS(BIN_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .op_i       (op_i),
    .red_i      (red_i),
    .green_i    (green_i),
    .blue_i     (blue_i),
    .bin_col_i  (bin_col_i),
    .bin_row_i  (bin_row_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .bin_count_o(bin_count_o)
  );

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the chroma vectorscope histogram.
`timescale 1ns / 1ps

module tb_top;

  // Bins per axis are 2^SCOPE_BITS; the scoreboard below assumes 8.
  localparam int unsigned SCOPE_BITS = 8;
  localparam int unsigned ITEMS      = 800;
  localparam int unsigned SETTLE     = 20;
  localparam int unsigned LIMIT      = 400000;

  // Q16 chroma coefficients and offsets for full-range BT.601.
  localparam int Q16_CB_R = 11059;
  localparam int Q16_CB_G = 21709;
  localparam int Q16_CB_B = 32768;
  localparam int Q16_CR_R = 32768;
  localparam int Q16_CR_G = 27439;
  localparam int Q16_CR_B = 5329;
  localparam int Q16_HALF = 128 * 65536;
  localparam int Q16_TOP  = 255 * 65536;

  typedef struct {
    logic       op;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] bin_col;
    logic [7:0] bin_row;
  } scope_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic op_i = cvh_pkg::OP_ADD;
  logic [7:0] red_i = '0;
  logic [7:0] green_i = '0;
  logic [7:0] blue_i = '0;
  logic [7:0] bin_col_i = '0;
  logic [7:0] bin_row_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [cvh_pkg::CNT_W-1:0] bin_count_o;

  // Requests waiting to be driven, and counts expected back from reads.
  scope_req_t pending_reqs[$];
  logic [cvh_pkg::CNT_W-1:0] due_counts[$];

  // Shadow of the count store, cleared like the block after reset.
  bit [cvh_pkg::CNT_W-1:0] scope_counts[65536];

  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  bit req_taken = 1'b0;
  scope_req_t next_req;
  logic [cvh_pkg::CNT_W-1:0] want_count;

  chroma_vectorscope_histogram #(
    .BIN_BITS(SCOPE_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .red_i      (red_i),
    .green_i    (green_i),
    .blue_i     (blue_i),
    .bin_col_i  (bin_col_i),
    .bin_row_i  (bin_row_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .bin_count_o(bin_count_o)
  );

  // Free-running 2 ns clock.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Maps a pixel to its bin index {row, col}; row is clamped at zero near pure red.
  function automatic logic [15:0] chroma_bin(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
    int cb;
    int cr;
    int t;
    logic [7:0] col;
    logic [7:0] row;
    cb = Q16_HALF - Q16_CB_R * int'(r) - Q16_CB_G * int'(g) + Q16_CB_B * int'(b);
    cr = Q16_HALF + Q16_CR_R * int'(r) - Q16_CR_G * int'(g) - Q16_CR_B * int'(b);
    t = Q16_TOP - cr;
    if (cb < 0) begin
      cb = 0;
    end
    col = cb[23:16];
    row = (t < 0) ? 8'd0 : t[23:16];
    return {row, col};
  endfunction

  // Updates the shadow store for one accepted request and queues any read result.
  task automatic apply_request(input logic op, input logic [7:0] r, input logic [7:0] g,
                               input logic [7:0] b, input logic [7:0] col,
                               input logic [7:0] row);
    logic [15:0] idx;
    if (op == cvh_pkg::OP_ADD) begin
      idx = chroma_bin(r, g, b);
      if (scope_counts[idx] != cvh_pkg::COUNT_MAX) begin
        scope_counts[idx] = scope_counts[idx] + 8'd1;
      end
    end else begin
      idx = {row, col};
      due_counts.push_back(scope_counts[idx]);
      scope_counts[idx] = '0;
    end
  endtask

  task automatic flag_mismatch(input string what);
    $display("tb_top: mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  // Idle length: mostly none or short, a few long, and none at all in quiet stretches.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (((cycles / 256) % 5) == 4) begin
      return 0;
    end
    if (roll < 55) begin
      return 0;
    end
    if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Bin bookkeeping for the stimulus generator: bins hit since they were last read.
  int unsigned hit_bins[$];
  bit gen_listed[65536];

  task automatic queue_add(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    scope_req_t req;
    int unsigned idx;
    req.op = cvh_pkg::OP_ADD;
    req.red = r;
    req.green = g;
    req.blue = b;
    req.bin_col = 8'($urandom);
    req.bin_row = 8'($urandom);
    pending_reqs.push_back(req);
    idx = 32'(chroma_bin(r, g, b));
    if (!gen_listed[idx]) begin
      gen_listed[idx] = 1'b1;
      hit_bins.push_back(idx);
    end
  endtask

  task automatic queue_read(input logic [15:0] idx);
    scope_req_t req;
    req.op = cvh_pkg::OP_READ;
    req.red = 8'($urandom);
    req.green = 8'($urandom);
    req.blue = 8'($urandom);
    req.bin_col = idx[7:0];
    req.bin_row = idx[15:8];
    pending_reqs.push_back(req);
  endtask

  // Cycle count and run limit.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Monitor: checks taken results, then records the request taken at this edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (due_counts.size() == 0) begin
          flag_mismatch($sformatf("unexpected result, count %0d", bin_count_o));
        end else begin
          want_count = due_counts.pop_front();
          if (bin_count_o !== want_count) begin
            flag_mismatch($sformatf("bin_count got %0d, want %0d", bin_count_o, want_count));
          end
        end
      end
      req_taken = in_valid_i && !in_stall_o;
      if (req_taken) begin
        apply_request(op_i, red_i, green_i, blue_i, bin_col_i, bin_row_i);
      end
    end
  end

  // Request driver: presents queued requests with random gaps and holds them while stalled.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || req_taken)) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        next_req = pending_reqs.pop_front();
        op_i <= next_req.op;
        red_i <= next_req.red;
        green_i <= next_req.green;
        blue_i <= next_req.blue;
        bin_col_i <= next_req.bin_col;
        bin_row_i <= next_req.bin_row;
        in_valid_i <= 1'b1;
        gap_left = pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result-side stall: random stretches of back-pressure.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      stall_left = pick_gap();
      out_stall_i <= 1'b0;
    end
  end

  // Stimulus, reset and end of run.
  initial begin : stimulus
    logic [7:0] pal_r[6];
    logic [7:0] pal_g[6];
    logic [7:0] pal_b[6];
    int unsigned n_colors;
    int unsigned frame;
    int unsigned n_hit;
    int unsigned pick;
    int unsigned idx;
    logic [15:0] sat_bin;

    // Directed: empty bins at the corners, the primaries, gray, and clear-on-read.
    queue_read(16'h0000);
    queue_read(16'hffff);
    queue_add(8'd0, 8'd0, 8'd0);
    queue_add(8'd255, 8'd255, 8'd255);
    queue_add(8'd255, 8'd0, 8'd0);
    queue_add(8'd255, 8'd0, 8'd0);
    queue_add(8'd0, 8'd255, 8'd0);
    queue_add(8'd0, 8'd0, 8'd255);
    queue_add(8'd255, 8'd255, 8'd0);
    queue_add(8'd0, 8'd255, 8'd255);
    queue_add(8'd255, 8'd0, 8'd255);
    queue_read(chroma_bin(8'd128, 8'd128, 8'd128));
    queue_read(chroma_bin(8'd255, 8'd0, 8'd0));
    queue_read(chroma_bin(8'd0, 8'd255, 8'd0));
    queue_read(chroma_bin(8'd0, 8'd0, 8'd255));
    queue_read(chroma_bin(8'd255, 8'd255, 8'd0));
    queue_read(chroma_bin(8'd0, 8'd255, 8'd255));
    queue_read(chroma_bin(8'd255, 8'd0, 8'd255));
    queue_read(chroma_bin(8'd0, 8'd0, 8'd0));
    foreach (hit_bins[i]) begin
      gen_listed[hit_bins[i]] = 1'b0;
    end
    hit_bins.delete();

    // Random frames: a burst of pixels from a small palette, then a partial readout.
    frame = 0;
    while (pending_reqs.size() < ITEMS) begin
      frame++;
      n_colors = $urandom_range(1, 6);
      for (int i = 0; i < 6; i++) begin
        pal_r[i] = 8'($urandom);
        pal_g[i] = 8'($urandom);
        pal_b[i] = 8'($urandom);
      end
      if (frame == 3) begin
        // One color hit 256 to 290 times, past the count limit, then read twice to see the clear.
        repeat ($urandom_range(256, 290)) begin
          queue_add(pal_r[0], pal_g[0], pal_b[0]);
        end
        sat_bin = chroma_bin(pal_r[0], pal_g[0], pal_b[0]);
        queue_read(sat_bin);
        queue_read(sat_bin);
      end else begin
        repeat ($urandom_range(4, 30)) begin
          if ($urandom_range(0, 9) == 0) begin
            queue_add(8'($urandom), 8'($urandom), 8'($urandom));
          end else begin
            pick = $urandom_range(0, n_colors - 1);
            queue_add(pal_r[pick], pal_g[pick], pal_b[pick]);
          end
        end
      end
      n_hit = hit_bins.size();
      for (int i = 0; i < n_hit; i++) begin
        idx = hit_bins.pop_front();
        if ($urandom_range(0, 9) < 7) begin
          queue_read(16'(idx));
          gen_listed[idx] = 1'b0;
        end else begin
          hit_bins.push_back(idx);
        end
      end
      repeat ($urandom_range(0, 3)) begin
        queue_read(16'($urandom));
      end
    end

    // Reset, then the driver presents requests, held by in_stall_o while the block clears.
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every request is taken and every read result has come back.
    while (pending_reqs.size() != 0 || in_valid_i || due_counts.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

[chroma_vectorscope_histogram.f]
rtl/core/cvh_pkg.sv
rtl/core/cvh_ram.sv
rtl/core/cvh_ctrl.sv
rtl/core/cvh_datapath.sv
rtl/core/chroma_vectorscope_histogram.sv
tb/sv/tb_top.sv
